### hw/rtl/assert_macros.svh
// Assertion macros for the array scan engine controller.
// Include guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/aoe_pkg.sv
// Package for the array scan engine: payload structs, codes, controller types.
// No dependencies.
`timescale 1ns / 1ps
package aoe_pkg;
  localparam int unsigned Depth = 128;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0, FUNC_READ = 3'd1, FUNC_ODD = 3'd2, FUNC_MIN = 3'd3,
    FUNC_REV = 3'd4, FUNC_REPL = 3'd5, FUNC_PRIME = 3'd6, FUNC_NONE = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK = 2'd0, STAT_EMPTY = 2'd1, STAT_RANGE = 2'd2, STAT_RSVD = 2'd3
  } status_e;

  localparam logic [0:0] RegLength = 1'b0;

  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         element_index;
    logic signed [31:0] match_value;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               found;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_RDW, ST_SCAN, ST_SCANW, ST_REVA, ST_REVB, ST_REVW,
    ST_REVX, ST_PDIV, ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            mem_we;
    logic [IdxW-1:0] mem_addr;
    logic [31:0]     mem_wdata;
    logic            load_a;     // capture read data into the A register
    logic            load_b;     // capture read data into the B register
    logic            acc_clear;
    logic            acc_step;   // fold read data into the accumulator
    logic            div_start;
    logic            div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] reg_a;
    logic [31:0] reg_b;
    logic [31:0] acc;
    logic        div_done;   // trial division finished
    logic        is_prime;
  } stat_t;
endpackage

### hw/rtl/array_operation_engine.sv
// Top level of the array scan engine: APB register, controller, datapath.
// Depends on aoe_pkg, aoe_ctrl and aoe_datapath.
//
//  channel   | ports                    | handshake
//  request   | start_i, req_i           | accepted when start_i && !busy_o
//  result    | done_o, rsp_o            | one-cycle strobe, no back-pressure
//  config    | psel .. prdata           | APB write, pready tied high
//
// Write and bad requests go from the accept cycle straight to the done state; read
// passes a read and a wait state; odd count, minimum and replace read each element
// in use through a read and a wait state, and reverse swaps pairs through REVA,
// REVB, REVW and REVX. Prime search runs the one-bit-per-cycle divider.
// The element RAM is not cleared by reset.
`timescale 1ns / 1ps
module array_operation_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  aoe_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output aoe_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  logic [7:0]             len_q;
  logic [aoe_pkg::CntW-1:0] len_eff;
  aoe_pkg::cmd_t          cmd;
  aoe_pkg::stat_t         stat;
  aoe_pkg::cmd_t          cmd_dp;
  logic                   pdiv_q;
  logic [2:0]             u_req_func;
  logic [2:0]             func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (psel && penable && pwrite && paddr == aoe_pkg::RegLength) begin
      len_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == aoe_pkg::RegLength) ? {24'd0, len_q} : 32'd0;
  assign len_eff = (len_q > 8'(aoe_pkg::Depth)) ? aoe_pkg::CntW'(aoe_pkg::Depth)
                                                : len_q[aoe_pkg::CntW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) func_q <= req_i.func;
  end
  assign u_req_func = func_q;

  // Divider start is raised on the first cycle of the prime test of each element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pdiv_q <= 1'b0;
    else pdiv_q <= cmd.load_a && (u_req_func == aoe_pkg::FUNC_PRIME);
  end

  always_comb begin
    cmd_dp           = cmd;
    cmd_dp.div_start = pdiv_q;
    cmd_dp.div_step  = cmd.div_step && !pdiv_q;
  end

  aoe_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .req_i (req_i),
    .len_i (len_eff),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy_o(busy_o),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  aoe_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .func_i(func_q),
    .cmd_i (cmd_dp),
    .stat_o(stat)
  );
endmodule

### hw/rtl/aoe_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module aoe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hw/rtl/aoe_datapath.sv
// Datapath: element RAM, scan accumulator, operand registers, trial divider.
// Depends on aoe_pkg and aoe_ram.
`timescale 1ns / 1ps
module aoe_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     func_i,
  input  aoe_pkg::cmd_t  cmd_i,
  output aoe_pkg::stat_t stat_o
);
  logic [31:0] rdata;
  logic [31:0] a_q, b_q, acc_q;
  logic [31:0] rem_q, div_q;
  logic [31:0] sq_q;        // div_q squared, kept incrementally
  logic [5:0]  bit_q;
  logic        div_busy_q, done_q, prime_q;
  logic [32:0] trial;

  aoe_ram #(.Width(32), .Depth(aoe_pkg::Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .addr_i (cmd_i.mem_addr),
    .wdata_i(cmd_i.mem_wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) a_q <= rdata;
    if (cmd_i.load_b) b_q <= rdata;
    if (cmd_i.acc_clear) begin
      // The first element seeds the accumulator for both scans.
      acc_q <= (func_i == aoe_pkg::FUNC_MIN) ? rdata : {31'd0, rdata[0]};
    end else if (cmd_i.acc_step) begin
      if (func_i == aoe_pkg::FUNC_MIN) begin
        if ($signed(rdata) < $signed(acc_q)) acc_q <= rdata;
      end else begin
        acc_q <= acc_q + {31'd0, rdata[0]};
      end
    end
  end

  // Restoring divider: one quotient bit per cycle, value in a_q, divisor div_q.
  assign trial = {rem_q, a_q[5'd31 - bit_q[4:0]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      done_q     <= 1'b0;
      prime_q    <= 1'b0;
      rem_q      <= '0;
      div_q      <= '0;
      sq_q       <= '0;
      bit_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        div_q      <= 32'd2;
        sq_q       <= 32'd4;
        rem_q      <= '0;
        bit_q      <= '0;
        div_busy_q <= !(a_q[31] || a_q < 32'd4);
        done_q     <= a_q[31] || a_q < 32'd4;
        prime_q    <= !a_q[31] && a_q >= 32'd2;
      end else if (div_busy_q && cmd_i.div_step) begin
        rem_q <= (trial[32:0] >= {1'b0, div_q}) ? trial[31:0] - div_q : trial[31:0];
        bit_q <= bit_q + 6'd1;
        if (bit_q == 6'd31) begin
          if (((trial[32:0] >= {1'b0, div_q}) ? trial[31:0] - div_q : trial[31:0]) == 0) begin
            div_busy_q <= 1'b0;
            done_q     <= 1'b1;
            prime_q    <= 1'b0;
          end else begin
            // Next divisor: (d+1)^2 = d^2 + 2d + 1; stop when beyond value.
            bit_q <= '0;
            rem_q <= '0;
            div_q <= div_q + 32'd1;
            if ({1'b0, sq_q} + {div_q, 1'b0} + 33'd1 > {1'b0, a_q}) begin
              div_busy_q <= 1'b0;
              done_q     <= 1'b1;
              prime_q    <= 1'b1;
            end
            sq_q <= sq_q + {div_q[30:0], 1'b0} + 32'd1;
          end
        end
      end
    end
  end

  assign stat_o.rdata    = rdata;
  assign stat_o.reg_a    = a_q;
  assign stat_o.reg_b    = b_q;
  assign stat_o.acc      = acc_q;
  assign stat_o.div_done = done_q;
  assign stat_o.is_prime = prime_q;
endmodule

### hw/rtl/aoe_ctrl.sv
// Controller state machine: sequences reads, writes and the divider.
// Depends on aoe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aoe_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  aoe_pkg::req_t           req_i,
  input  logic [aoe_pkg::CntW-1:0] len_i,
  input  aoe_pkg::stat_t          stat_i,
  output aoe_pkg::cmd_t           cmd_o,
  output logic                    busy_o,
  output logic                    done_o,
  output aoe_pkg::rsp_t           rsp_o
);
  localparam int unsigned IW = aoe_pkg::IdxW;
  localparam int unsigned CW = aoe_pkg::CntW;

  aoe_pkg::state_e state_q, state_d;
  aoe_pkg::req_t   req_q;
  logic [CW-1:0]   i_q, i_d;
  logic [CW-1:0]   n;
  aoe_pkg::rsp_t   rsp_q, rsp_d;
  logic            done_q, done_d;
  logic [CW-1:0]   j;

  assign n = len_i;
  assign j = n - CW'(1) - i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aoe_pkg::ST_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == aoe_pkg::ST_IDLE) req_q <= req_i;
    rsp_q <= rsp_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    unique case (state_q)
      aoe_pkg::ST_IDLE: begin
        i_d = '0;
        if (start_i) begin
          if (req_i.func == aoe_pkg::FUNC_NONE || n == 0 ||
              (req_i.func == aoe_pkg::FUNC_WRITE && {1'b0, req_i.element_index} >= n) ||
              (req_i.func == aoe_pkg::FUNC_READ && {1'b0, req_i.element_index} >= n) ||
              req_i.func == aoe_pkg::FUNC_WRITE) begin
            state_d = aoe_pkg::ST_DONE;
          end else if (req_i.func == aoe_pkg::FUNC_READ) begin
            state_d = aoe_pkg::ST_RD;
          end else if (req_i.func == aoe_pkg::FUNC_REV) begin
            state_d = (n < 2) ? aoe_pkg::ST_DONE : aoe_pkg::ST_REVA;
          end else begin
            state_d = aoe_pkg::ST_SCAN;
          end
        end
      end
      aoe_pkg::ST_RD:  state_d = aoe_pkg::ST_RDW;
      aoe_pkg::ST_RDW: state_d = aoe_pkg::ST_DONE;
      aoe_pkg::ST_SCAN: state_d = aoe_pkg::ST_SCANW;
      aoe_pkg::ST_SCANW: begin
        // Read data for element i_q is present now.
        if (req_q.func == aoe_pkg::FUNC_PRIME) begin
          state_d = aoe_pkg::ST_PDIV;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = (i_q + 1 >= n) ? aoe_pkg::ST_DONE : aoe_pkg::ST_SCAN;
        end
      end
      aoe_pkg::ST_PDIV: begin
        if (stat_i.div_done) begin
          if (stat_i.is_prime) begin
            state_d = aoe_pkg::ST_DONE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = (i_q + 1 >= n) ? aoe_pkg::ST_DONE : aoe_pkg::ST_SCAN;
          end
        end
      end
      aoe_pkg::ST_REVA: state_d = aoe_pkg::ST_REVB;
      aoe_pkg::ST_REVB: state_d = aoe_pkg::ST_REVW;
      aoe_pkg::ST_REVW: state_d = aoe_pkg::ST_REVX;
      aoe_pkg::ST_REVX: begin
        i_d     = i_q + CW'(1);
        state_d = (i_q + 1 >= (n >> 1)) ? aoe_pkg::ST_DONE : aoe_pkg::ST_REVA;
      end
      aoe_pkg::ST_DONE: state_d = aoe_pkg::ST_IDLE;
      default: state_d = aoe_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o  = '0;
    rsp_d  = rsp_q;
    done_d = 1'b0;
    unique case (state_q)
      aoe_pkg::ST_IDLE: begin
        rsp_d = '0;
        if (start_i) begin
          if (req_i.func == aoe_pkg::FUNC_NONE) begin
            rsp_d.status = aoe_pkg::STAT_OK;
          end else if (n == 0) begin
            rsp_d.status = aoe_pkg::STAT_EMPTY;
          end else if ((req_i.func == aoe_pkg::FUNC_WRITE ||
                        req_i.func == aoe_pkg::FUNC_READ) &&
                       {1'b0, req_i.element_index} >= n) begin
            rsp_d.status = aoe_pkg::STAT_RANGE;
          end else begin
            rsp_d.found = 1'b1;
            if (req_i.func == aoe_pkg::FUNC_WRITE) begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.mem_addr  = req_i.element_index[IW-1:0];
              cmd_o.mem_wdata = req_i.match_value;
            end else if (req_i.func == aoe_pkg::FUNC_PRIME) begin
              rsp_d.found        = 1'b0;
              rsp_d.result_value = -32'sd1;
            end
          end
        end
      end
      aoe_pkg::ST_RD: cmd_o.mem_addr = req_q.element_index[IW-1:0];
      aoe_pkg::ST_RDW: rsp_d.result_value = stat_i.rdata;
      aoe_pkg::ST_SCAN: cmd_o.mem_addr = i_q[IW-1:0];
      aoe_pkg::ST_SCANW: begin
        cmd_o.mem_addr = i_q[IW-1:0];
        unique case (req_q.func)
          aoe_pkg::FUNC_ODD, aoe_pkg::FUNC_MIN: begin
            cmd_o.acc_clear = (i_q == 0);
            cmd_o.acc_step  = (i_q != 0);
          end
          aoe_pkg::FUNC_REPL: begin
            if (stat_i.rdata == req_q.match_value) begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.mem_wdata = req_q.new_value;
            end
          end
          aoe_pkg::FUNC_PRIME: cmd_o.load_a = 1'b1;
          default: ;
        endcase
      end
      aoe_pkg::ST_PDIV: begin
        cmd_o.div_start = !stat_i.div_done && state_q != state_d ? 1'b0 : 1'b0;
        cmd_o.div_step  = 1'b1;
        if (stat_i.div_done && stat_i.is_prime) begin
          rsp_d.found        = 1'b1;
          rsp_d.result_value = {{(32-CW){1'b0}}, i_q};
        end
      end
      aoe_pkg::ST_REVA: cmd_o.mem_addr = i_q[IW-1:0];
      aoe_pkg::ST_REVB: begin
        cmd_o.mem_addr = j[IW-1:0];
        cmd_o.load_a   = 1'b1;
      end
      aoe_pkg::ST_REVW: begin
        cmd_o.load_b    = 1'b1;
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_addr  = j[IW-1:0];
        cmd_o.mem_wdata = stat_i.reg_a;
      end
      aoe_pkg::ST_REVX: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.mem_addr  = i_q[IW-1:0];
        cmd_o.mem_wdata = stat_i.reg_b;
      end
      aoe_pkg::ST_DONE: begin
        done_d = 1'b1;
        if (req_q.func == aoe_pkg::FUNC_ODD || req_q.func == aoe_pkg::FUNC_MIN) begin
          if (rsp_q.found) rsp_d.result_value = stat_i.acc;
        end
      end
      default: ;
    endcase
    // Divider launches the cycle after the candidate is captured.
    if (state_q == aoe_pkg::ST_SCANW && req_q.func == aoe_pkg::FUNC_PRIME) begin
      cmd_o.div_start = 1'b0;
    end
  end

  assign busy_o = (state_q != aoe_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, state_q == aoe_pkg::ST_IDLE)
  `ASSERT_IMPL(a_rev_bound, clk_i, rst_ni, state_q == aoe_pkg::ST_REVX, i_q < n)
endmodule

### verif/testbench.sv
// Self-checking testbench for array_operation_engine: commands on start_i/req_i,
// results on done_o/rsp_o, array length over the APB port.
// Depends on aoe_pkg and the array_operation_engine RTL.
`timescale 1ns / 1ps
module testbench;

  // Shadow copy of the element array; predicts the response of each request.
  class array_scoreboard;
    logic signed [31:0] elems[128];
    logic [7:0] length;
    aoe_pkg::rsp_t expected_rsps[$];
    int errors;
    int mismatches;

    function new();
      length = 8'd0;
      errors = 0;
      mismatches = 0;
      foreach (elems[i]) elems[i] = 32'sd0;
    endfunction

    function bit prime_value(logic signed [31:0] v);
      longint x;
      longint d;
      x = v;
      if (x < 2) return 1'b0;
      for (d = 2; d * d <= x; d++) if (x % d == 0) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(aoe_pkg::req_t r);
      aoe_pkg::rsp_t e;
      int unsigned n;
      logic signed [31:0] t;
      e = '0;
      n = (length > 8'd128) ? 128 : length;
      if (r.func == aoe_pkg::FUNC_NONE) begin
        e.status = aoe_pkg::STAT_OK;
      end else if (n == 0) begin
        e.status = aoe_pkg::STAT_EMPTY;
      end else if ((r.func == aoe_pkg::FUNC_WRITE || r.func == aoe_pkg::FUNC_READ) &&
                   r.element_index >= n) begin
        e.status = aoe_pkg::STAT_RANGE;
      end else begin
        e.found = 1'b1;
        e.status = aoe_pkg::STAT_OK;
        case (r.func)
          aoe_pkg::FUNC_WRITE: elems[r.element_index] = r.match_value;
          aoe_pkg::FUNC_READ: e.result_value = elems[r.element_index];
          aoe_pkg::FUNC_ODD: for (int i = 0; i < n; i++) e.result_value += elems[i][0];
          aoe_pkg::FUNC_MIN: begin
            e.result_value = elems[0];
            for (int i = 1; i < n; i++)
              if (elems[i] < e.result_value) e.result_value = elems[i];
          end
          aoe_pkg::FUNC_REV: begin
            for (int i = 0; i < n / 2; i++) begin
              t = elems[i];
              elems[i] = elems[n - 1 - i];
              elems[n - 1 - i] = t;
            end
          end
          aoe_pkg::FUNC_REPL: begin
            for (int i = 0; i < n; i++)
              if (elems[i] == r.match_value) elems[i] = r.new_value;
          end
          default: begin
            e.result_value = -32'sd1;
            e.found = 1'b0;
            for (int i = 0; i < n; i++) begin
              if (prime_value(elems[i])) begin
                e.result_value = i;
                e.found = 1'b1;
                break;
              end
            end
          end
        endcase
      end
      expected_rsps.push_back(e);
    endfunction

    function void check_result(aoe_pkg::rsp_t got);
      aoe_pkg::rsp_t e;
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %h", got);
        return;
      end
      e = expected_rsps.pop_front();
      if (got.result_value !== e.result_value || got.found !== e.found ||
          got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d found %0b status %0d, got %0d %0b %0d",
                   e.result_value, e.found, e.status,
                   got.result_value, got.found, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  aoe_pkg::req_t req = '0;
  logic busy, done;
  aoe_pkg::rsp_t rsp;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  array_scoreboard sb = new();
  bit written[128];
  int idle_pct;
  int stall_cycles;

  always #6 clk = ~clk;

  array_operation_engine i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .req_i(req), .busy_o(busy),
    .done_o(done), .rsp_o(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk) begin
    if (rst_n && done) sb.check_result(rsp);
  end

  // Watchdog: a long prime search on small odd values still stays far below this.
  always @(posedge clk) begin
    if (!rst_n || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 3000000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Element values: positive odd values stay small so that trial division stays short.
  function automatic logic signed [31:0] element_value();
    logic signed [31:0] v;
    case ($urandom_range(3))
      0: v = $signed($urandom_range(100)) - 32'sd50;
      1: v = $urandom_range(4095);
      default: begin
        v = $urandom;
        if (v >= 4096) v[0] = 1'b0;
      end
    endcase
    return v;
  endfunction

  task automatic send(aoe_pkg::req_t r);
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    // Only a write that the block takes fills a slot.
    if (r.func == aoe_pkg::FUNC_WRITE && sb.length != 8'd0 &&
        {1'b0, r.element_index} < ((sb.length > 8'd128) ? 8'd128 : sb.length))
      written[r.element_index] = 1'b1;
    sb.note_request(r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic write_length(logic [7:0] len);
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= aoe_pkg::RegLength;
    pwdata <= {24'd0, len};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.length = len;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_op(aoe_pkg::func_e f, int idx, logic signed [31:0] a,
                         logic signed [31:0] b);
    aoe_pkg::req_t r;
    r.func = f;
    r.element_index = 7'(idx);
    r.match_value = a;
    r.new_value = b;
    send(r);
  endtask

  // Every index in use is written before any scan may touch it.
  task automatic fill_array();
    int n;
    n = (sb.length > 8'd128) ? 128 : sb.length;
    for (int i = 0; i < n; i++)
      if (!written[i]) send_op(aoe_pkg::FUNC_WRITE, i, element_value(), 32'sd0);
  endtask

  task automatic random_ops(int count);
    int n;
    int pick;
    aoe_pkg::req_t r;
    n = (sb.length > 8'd128) ? 128 : sb.length;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      r.element_index = (n > 0 && $urandom_range(9) < 8) ? 7'($urandom_range(n - 1))
                                                         : 7'($urandom_range(127));
      r.match_value = element_value();
      r.new_value = element_value();
      if (pick < 22) r.func = aoe_pkg::FUNC_WRITE;
      else if (pick < 38) r.func = aoe_pkg::FUNC_READ;
      else if (pick < 48) r.func = aoe_pkg::FUNC_ODD;
      else if (pick < 58) r.func = aoe_pkg::FUNC_MIN;
      else if (pick < 68) r.func = aoe_pkg::FUNC_REV;
      else if (pick < 82) begin
        r.func = aoe_pkg::FUNC_REPL;
        if (n > 0 && $urandom_range(1)) r.match_value = sb.elems[$urandom_range(n - 1)];
      end else if (pick < 95) r.func = aoe_pkg::FUNC_PRIME;
      else r.func = aoe_pkg::FUNC_NONE;
      // A read outside the array changes nothing, so only in-range reads need a written slot.
      if (r.func == aoe_pkg::FUNC_READ && r.element_index < n && !written[r.element_index])
        r.func = aoe_pkg::FUNC_ODD;
      send(r);
    end
  endtask

  initial begin
    logic [7:0] lens[7];
    logic [7:0] len;
    lens = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd200, 8'd255};
    idle_pct = 34;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty array: every operation reports empty, the unused code reports ok.
    for (int f = 0; f < 8; f++) send_op(aoe_pkg::func_e'(f), 0, 32'sd5, 32'sd6);

    write_length(8'd4);
    send_op(aoe_pkg::FUNC_WRITE, 0, 32'sh80000000, 32'sd0);
    send_op(aoe_pkg::FUNC_WRITE, 1, 32'sh7ffffffe, 32'sd0);
    send_op(aoe_pkg::FUNC_WRITE, 2, 32'sd1, 32'sd0);
    send_op(aoe_pkg::FUNC_WRITE, 3, -32'sd1, 32'sd0);
    send_op(aoe_pkg::FUNC_WRITE, 4, 32'sd3, 32'sd0);
    send_op(aoe_pkg::FUNC_READ, 127, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_READ, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_ODD, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_MIN, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_PRIME, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_REV, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_READ, 3, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_REPL, 0, 32'sh7fffffff, 32'sd9);
    send_op(aoe_pkg::FUNC_REPL, 0, -32'sd1, 32'sd2);
    send_op(aoe_pkg::FUNC_PRIME, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_READ, 0, 32'sd0, 32'sd0);
    send_op(aoe_pkg::FUNC_NONE, 127, -32'sd1, -32'sd1);

    for (int p = 0; p < 30; p++) begin
      if (p == 10) idle_pct = 54;
      if (p == 20) idle_pct = 0;
      if (p < 7) len = lens[p];
      else if ($urandom_range(9) < 7) len = 8'($urandom_range(1, 12));
      else len = 8'($urandom_range(255));
      write_length(len);
      fill_array();
      random_ops(55);
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.mismatches == 0 && sb.expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
